// ===== hdl/ist_pkg.sv =====
// ----------------------------------------------------------------------------
// ist_pkg: shared types and codes for the integer set table
// Operation and status codes, and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_FALSE = 2'd0;
  localparam logic [1:0] ST_TRUE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned MembW  = 5;

  typedef struct packed {
    logic load;     // capture the accepted item
    logic compare;  // compare the item against every cell
    logic update;   // apply the operation and register the result
  } ist_cmd_t;

endpackage

// ===== hdl/ist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ist_ctrl: request sequencer for the integer set table
// Steps each item through capture, compare and update, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module ist_ctrl
  import ist_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ist_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign out_busy    = out_valid_r && out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.load    = in_valid && (state_r == S_IDLE);
  assign cmd.compare = (state_r == S_CMP);
  assign cmd.update  = (state_r == S_UPD) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CMP;
      end
      S_CMP: state_nxt = S_UPD;
      S_UPD: begin
        if (!out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.update) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/ist_dp.sv =====
// ----------------------------------------------------------------------------
// ist_dp: cell row and result register of the integer set table
// Holds the packed entries, compares a value against every cell at once,
// and appends, shifts out or reports as commanded.
// ----------------------------------------------------------------------------
module ist_dp
  import ist_pkg::*;
#(
  parameter int unsigned SET_CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ist_cmd_t          cmd,
  input  logic [OpW-1:0]    in_operation,
  input  logic [ValueW-1:0] in_item_value,
  output logic [StatW-1:0]  out_status,
  output logic [MembW-1:0]  out_member_count
);

  localparam int unsigned CntW = $clog2(SET_CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(SET_CAPACITY);

  logic [ValueW-1:0]       cells_r [SET_CAPACITY];
  logic [CntW-1:0]         count_r, count_nxt;
  logic [OpW-1:0]          op_r;
  logic [ValueW-1:0]       value_r;
  logic [SET_CAPACITY-1:0] match_r;
  logic [StatW-1:0]        status_r, status_nxt;
  logic [MembW-1:0]        member_r;
  logic [CntW+MembW-1:0]   count_ext;

  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic            do_append;
  logic            do_remove;
  logic [IdxW-1:0] tail_idx;

  assign hit      = |match_r;
  assign tail_idx = count_r[IdxW-1:0];
  assign count_ext = {{MembW{1'b0}}, count_nxt};

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SET_CAPACITY; i++) begin
      if (match_r[i]) hit_idx = hit_idx | IdxW'(i);
    end
  end

  always_comb begin
    status_nxt = ST_FALSE;
    count_nxt  = count_r;
    do_append  = 1'b0;
    do_remove  = 1'b0;
    case (op_r)
      OP_LOOKUP: status_nxt = hit ? ST_TRUE : ST_FALSE;
      OP_INSERT: begin
        if (hit) begin
          status_nxt = ST_FALSE;
        end else if (count_r == CntW'(SET_CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_TRUE;
          do_append  = 1'b1;
          count_nxt  = count_r + CntW'(1);
        end
      end
      OP_DELETE: begin
        if (hit) begin
          status_nxt = ST_TRUE;
          do_remove  = 1'b1;
          count_nxt  = count_r - CntW'(1);
        end
      end
      default: status_nxt = ST_FALSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      value_r <= in_item_value;
    end
    if (cmd.compare) begin
      for (int i = 0; i < SET_CAPACITY; i++) begin
        match_r[i] <= (cells_r[i] == value_r) && (CntW'(i) < count_r);
      end
    end
    if (cmd.update) begin
      status_r <= status_nxt;
      member_r <= count_ext[MembW-1:0];
      for (int i = 0; i < SET_CAPACITY; i++) begin
        if (do_append && (tail_idx == IdxW'(i))) begin
          cells_r[i] <= value_r;
        end
      end
      for (int i = 0; i + 1 < SET_CAPACITY; i++) begin
        if (do_remove && (IdxW'(i) >= hit_idx) && (CntW'(i + 1) < count_r)) begin
          cells_r[i] <= cells_r[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.update) begin
      count_r <= count_nxt;
    end
  end

  assign out_status       = status_r;
  assign out_member_count = member_r;

endmodule

// ===== hdl/integer_set_table.sv =====
// ----------------------------------------------------------------------------
// integer_set_table: fixed-capacity set of distinct signed 32-bit values
// Lookup, insert and delete requests against a packed, insertion-ordered
// row of SET_CAPACITY cells.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_*: in_operation (0 lookup, 1 insert, 2 delete) and
//   in_item_value. An item is taken when in_valid is high and in_stall low.
//   Result channel out_*: out_status (0 false, 1 true, 2 full) and
//   out_member_count, the number of stored values after the request.
//   Every item gives exactly one result, in order.
//   Sequence: an item passes through capture, a compare of the value against
//   all cells at once, then the update, which writes the result into the
//   output register. No new item is taken until the update of the last one
//   is done, and that update holds while the output register is stalled.
//   The compare-then-update order of the cell row sets these steps.
//   A delete moves every later cell down one place in the update cycle.
//   Reset empties the set at once; no clearing pass is needed.
//   While the receiver stalls a pending result, a new item may still be
//   taken; its update holds until the output register is free.
// ----------------------------------------------------------------------------
module integer_set_table
  import ist_pkg::*;
#(
  parameter int unsigned SET_CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic signed [31:0]       in_item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [4:0]               out_member_count
);

  ist_cmd_t cmd;

  ist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ist_dp #(
    .SET_CAPACITY (SET_CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_item_value    (in_item_value),
    .out_status       (out_status),
    .out_member_count (out_member_count)
  );

endmodule

// ===== tb/integer_set_table_tb.sv =====
// ----------------------------------------------------------------------------
// integer_set_table_tb: self-checking bench for the integer set table
// Runs a directed sequence (empty set, extreme values, duplicates, the unused
// operation, a full set) and then random requests drawn mostly from a small
// pool of values, so that hits, misses, deletes and full inserts all recur.
// A local copy of the set predicts each result. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module integer_set_table_tb
  import ist_pkg::*;
();

  localparam int unsigned SET_CAPACITY = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          POOL_SIZE    = 24;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          QUIET_LIMIT  = 1000;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] count;
  } set_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        typed;
    set_result_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_operation;
  logic signed [31:0] in_item_value;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [4:0] out_member_count;

  logic [31:0] set_cells [SET_CAPACITY];
  int set_size = 0;
  set_result_t pending_results[$];
  dir_row_t dir_rows[$];
  logic [31:0] value_pool [POOL_SIZE];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_stretch = 0;
  bit send_idles = 1'b1;

  integer_set_table #(
    .SET_CAPACITY(SET_CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_item_value(in_item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_member_count(out_member_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic set_result_t apply_request(logic [1:0] op, logic [31:0] value);
    int hit;
    int i;
    set_result_t r;
    hit = -1;
    for (i = 0; i < set_size; i++) begin
      if (hit < 0 && set_cells[i] == value) hit = i;
    end
    r.status = ST_FALSE;
    case (op)
      OP_LOOKUP: begin
        if (hit >= 0) r.status = ST_TRUE;
      end
      OP_INSERT: begin
        if (hit < 0) begin
          if (set_size >= SET_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            set_cells[set_size] = value;
            set_size++;
            r.status = ST_TRUE;
          end
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i < set_size - 1; i++) set_cells[i] = set_cells[i + 1];
          set_size--;
          r.status = ST_TRUE;
        end
      end
      default: begin
      end
    endcase
    r.count = 5'(set_size);
    return r;
  endfunction

  function automatic dir_row_t row_of(logic [1:0] op, logic [31:0] value, logic typed,
                                      logic [1:0] status, logic [4:0] count);
    dir_row_t row;
    row.op = op;
    row.value = value;
    row.typed = typed;
    row.result.status = status;
    row.result.count = count;
    return row;
  endfunction

  function automatic int draw_wait(ref int stretch, ref bit idles);
    if (stretch == 0) begin
      stretch = $urandom_range(20, 60);
      idles = ($urandom_range(0, 2) != 0);
    end
    stretch--;
    return idles ? $urandom_range(0, 5) : 0;
  endfunction

  task automatic send_request(logic [1:0] op, logic [31:0] value, logic typed,
                              set_result_t typed_result);
    int gap;
    set_result_t predicted;
    gap = draw_wait(send_stretch, send_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_item_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(op, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  initial begin
    int n;
    logic [1:0] op;
    logic [31:0] value;
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_LOOKUP;
    in_item_value <= '0;

    dir_rows.push_back(row_of(OP_LOOKUP, 32'h0000_0000, 1'b1, ST_FALSE, 5'd0));
    dir_rows.push_back(row_of(OP_DELETE, 32'h7FFF_FFFF, 1'b1, ST_FALSE, 5'd0));
    dir_rows.push_back(row_of(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, ST_FALSE, 5'd0));
    dir_rows.push_back(row_of(OP_INSERT, 32'h8000_0000, 1'b1, ST_TRUE, 5'd1));
    dir_rows.push_back(row_of(OP_INSERT, 32'h7FFF_FFFF, 1'b1, ST_TRUE, 5'd2));
    dir_rows.push_back(row_of(OP_INSERT, 32'hFFFF_FFFF, 1'b1, ST_TRUE, 5'd3));
    dir_rows.push_back(row_of(OP_INSERT, 32'h8000_0000, 1'b1, ST_FALSE, 5'd3));
    dir_rows.push_back(row_of(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, ST_TRUE, 5'd3));
    dir_rows.push_back(row_of(OP_DELETE, 32'h8000_0000, 1'b1, ST_TRUE, 5'd2));
    dir_rows.push_back(row_of(OP_UNUSED, 32'h7FFF_FFFF, 1'b1, ST_FALSE, 5'd2));
    for (n = 0; n < 13; n++) begin
      dir_rows.push_back(row_of(OP_INSERT, 32'(n), 1'b0, ST_FALSE, 5'd0));
    end
    dir_rows.push_back(row_of(OP_INSERT, 32'hA5A5_A5A5, 1'b0, ST_FALSE, 5'd0));
    dir_rows.push_back(row_of(OP_INSERT, 32'h5555_5555, 1'b1, ST_FULL, 5'd16));
    dir_rows.push_back(row_of(OP_INSERT, 32'h7FFF_FFFF, 1'b1, ST_FALSE, 5'd16));
    dir_rows.push_back(row_of(OP_DELETE, 32'hA5A5_A5A5, 1'b1, ST_TRUE, 5'd15));
    dir_rows.push_back(row_of(OP_DELETE, 32'h7FFF_FFFF, 1'b1, ST_TRUE, 5'd14));
    dir_rows.push_back(row_of(OP_LOOKUP, 32'hA5A5_A5A5, 1'b1, ST_FALSE, 5'd14));
    dir_rows.push_back(row_of(OP_LOOKUP, 32'h0000_0000, 1'b0, ST_FALSE, 5'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                   dir_rows[i].result);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0000_0000;
        for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
      end
      pick = $urandom_range(0, 99);
      if ((n / 100) % 2 == 0) begin
        op = (pick < 50) ? OP_INSERT : (pick < 70) ? OP_DELETE :
             (pick < 95) ? OP_LOOKUP : OP_UNUSED;
      end else begin
        op = (pick < 25) ? OP_INSERT : (pick < 70) ? OP_DELETE :
             (pick < 95) ? OP_LOOKUP : OP_UNUSED;
      end
      if ($urandom_range(0, 99) < 85) value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      else value = $urandom;
      send_request(op, value, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int hold;
    int stretch;
    bit idles;
    stretch = 0;
    idles = 1'b1;
    out_stall <= 1'b0;
    forever begin
      hold = draw_wait(stretch, idles);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    set_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: out_status %0d, out_member_count %0d",
               out_status, out_member_count);
        mismatch_count++;
      end else begin
        head = pending_results.pop_front();
        if (out_status !== head.status) begin
          $error("out_status: expected %0d, actual %0d", head.status, out_status);
          mismatch_count++;
        end
        if (out_member_count !== head.count) begin
          $error("out_member_count: expected %0d, actual %0d", head.count,
                 out_member_count);
          mismatch_count++;
        end
      end
    end
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
